// ===== rtl/dmsf_pkg.sv =====
// Shared constants for the differential mixer with speed feedback.
package dmsf_pkg;

  localparam int PCT_W   = 8;     // throttle and steering width
  localparam int CNT_W   = 10;    // encoder count width
  localparam int RPS_W   = 10;    // max_rps register width
  localparam int DRV_W   = 10;    // signed drive width
  localparam int MAG_W   = 9;     // drive magnitude / previous request width
  localparam int GAIN_W  = 10;    // unsigned Q2.8 gain
  localparam int PROD_W  = 20;    // shared multiplier product width
  localparam int NUM_W   = 28;    // divider dividend width
  localparam int DEN_W   = 18;    // divider divisor width
  localparam int QUO_W   = 10;    // quotient bits produced per division
  localparam int STEP_W  = 4;     // divider step counter width

  localparam logic [RPS_W-1:0]  MAX_RPS_RST = 10'd250;
  localparam logic [12:0]       MIX_RECIP   = 13'd5243;   // ceil(2^18 / 50)
  localparam int                MIX_SHIFT   = 18;
  localparam logic [GAIN_W-1:0] GAIN_ONE    = 10'd256;
  localparam logic [GAIN_W-1:0] GAIN_STALL  = 10'd512;
  localparam logic [GAIN_W-1:0] GAIN_MIN    = 10'd128;
  localparam logic [GAIN_W-1:0] GAIN_MAX    = 10'd768;
  localparam logic [MAG_W-1:0]  DRIVE_LIM   = 9'd511;
  localparam logic [STEP_W-1:0] LAST_STEP   = 4'(QUO_W - 1);

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

endpackage

// ===== rtl/differential_mix_speed_feedback.sv =====
// Differential drive mixer: arcade mixing plus per-motor speed feedback gain.
//
// One request per control tick carries throttle, steering and both encoder
// counts; one request comes back with the adjusted right and left drives and
// the gains applied (unsigned Q2.8, 0.5 to 3.0). Two-variable products use one
// shared 10x10 multiplier; channel divisions use one restoring divider that
// yields ten quotient bits, one bit per cycle, under a small sequencer. The
// steering map divides by a constant through a separate reciprocal multiply;
// each motor channel then divides and applies its gain. An item occupies the
// block from acceptance until its result enters the output register, during
// which s_tready is low. The output register lets the next request be taken
// while a finished result waits. max_rps may be written only while idle.
module differential_mix_speed_feedback
  import dmsf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // config
  input  logic                  cfg_wen,
  input  logic [RPS_W-1:0]      cfg_wdata,    // max_rps
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,      // throttle_pct[7:0], steer_pct[15:8],
                                              // count_right[25:16], count_left[35:26]
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata       // right_drive[9:0], left_drive[19:10],
                                              // right_gain[29:20], left_gain[39:30]
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_LOAD, S_DIV, S_POST, S_AMUL, S_ADONE, S_OUT
  } state_t;

  typedef enum logic [1:0] {PH_MIX, PH_RIGHT, PH_LEFT} phase_t;

  state_t state;
  phase_t phase;

  logic [RPS_W-1:0]         max_rps;
  logic signed [PCT_W-1:0]  thr;
  logic signed [PCT_W-1:0]  steer;
  logic [CNT_W-1:0]         cnt_r, cnt_l;
  logic signed [DRV_W-1:0]  drv_r, drv_l;     // mixed drives before gain
  logic signed [DRV_W-1:0]  adj_r, adj_l;     // drives after gain
  logic [GAIN_W-1:0]        gain_r, gain_l;
  logic [MAG_W-1:0]         prev_r, prev_l;
  logic [PROD_W-1:0]        prod;
  logic [NUM_W-1:0]         rem, dsh;
  logic [QUO_W-1:0]         quo;
  logic                     ovf;
  logic [STEP_W-1:0]        step;
  logic                     out_valid;
  logic [OUT_DATA_W-1:0]    out_data;

  // operand selection and datapath
  logic [PCT_W-1:0]         thr_mag, steer_mag;
  logic signed [DRV_W-1:0]  cur_drv;
  logic [MAG_W-1:0]         cur_mag, cur_prev;
  logic [CNT_W-1:0]         cur_cnt;
  logic [GAIN_W-1:0]        cur_gain;
  logic [DRV_W-1:0]         req_sum;
  logic [9:0]               mul_a, mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic [PROD_W+12:0]       mix_scaled;
  logic [NUM_W-1:0]         num;
  logic [DEN_W-1:0]         den;
  logic                     fits;
  logic signed [DRV_W:0]    thr_ext, sec;
  logic [GAIN_W-1:0]        gain_calc;
  logic [PROD_W:0]          rnd;
  logic [PROD_W-8:0]        mag_sh;
  logic [MAG_W-1:0]         mag_sat;
  logic signed [DRV_W-1:0]  adj;

  assign thr_mag   = thr[PCT_W-1]   ? PCT_W'(-thr)   : PCT_W'(thr);
  assign steer_mag = steer[PCT_W-1] ? PCT_W'(-steer) : PCT_W'(steer);

  assign cur_drv  = (phase == PH_RIGHT) ? drv_r  : drv_l;
  assign cur_mag  = cur_drv[DRV_W-1] ? MAG_W'(-cur_drv) : MAG_W'(cur_drv);
  assign cur_prev = (phase == PH_RIGHT) ? prev_r : prev_l;
  assign cur_cnt  = (phase == PH_RIGHT) ? cnt_r  : cnt_l;
  assign cur_gain = (phase == PH_RIGHT) ? gain_r : gain_l;
  assign req_sum  = DRV_W'(cur_prev) + DRV_W'(cur_mag);

  always_comb begin
    if (state == S_AMUL) begin
      mul_a = 10'(cur_mag);
      mul_b = cur_gain;
    end else if (phase == PH_MIX) begin
      mul_a = 10'(steer_mag);
      mul_b = 10'(thr_mag);
    end else begin
      mul_a = req_sum;
      mul_b = max_rps;
    end
  end
  assign mul_p = mul_a * mul_b;

  // 2*prod/100 as prod * ceil(2^18/50) >> 18, exact while prod stays below 43691
  assign mix_scaled = (PROD_W+13)'(prod) * (PROD_W+13)'(MIX_RECIP);

  assign num = {prod, 8'b0};
  // 200 * count as shift-add
  assign den = DEN_W'({cur_cnt, 7'b0}) + DEN_W'({cur_cnt, 6'b0}) + DEN_W'({cur_cnt, 3'b0});

  assign fits = (rem >= dsh);

  // secondary motor: thr - sign(thr) * trunc(2*|thr|*|steer| / 100)
  assign thr_ext = (DRV_W+1)'(thr);
  assign sec = thr[PCT_W-1] ? thr_ext + $signed({1'b0, quo})
                            : thr_ext - $signed({1'b0, quo});

  always_comb begin
    if (cur_cnt == '0) begin
      gain_calc = (req_sum != '0) ? GAIN_STALL : GAIN_ONE;
    end else if (ovf || quo > GAIN_MAX) begin
      gain_calc = GAIN_MAX;
    end else if (quo < GAIN_MIN) begin
      gain_calc = GAIN_MIN;
    end else begin
      gain_calc = quo;
    end
  end

  // round half away from zero on magnitude, then saturate
  assign rnd     = (PROD_W+1)'(prod) + (PROD_W+1)'(128);
  assign mag_sh  = rnd[PROD_W:8];
  assign mag_sat = (mag_sh > (PROD_W-7)'(DRIVE_LIM)) ? DRIVE_LIM : mag_sh[MAG_W-1:0];
  assign adj     = cur_drv[DRV_W-1] ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_MIX;
      max_rps   <= MAX_RPS_RST;
      prev_r    <= '0;
      prev_l    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        max_rps <= cfg_wdata;
      end
      if (state == S_OUT && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            thr   <= s_tdata[7:0];
            steer <= s_tdata[15:8];
            cnt_r <= s_tdata[25:16];
            cnt_l <= s_tdata[35:26];
            phase <= PH_MIX;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= mul_p;
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (phase == PH_MIX) begin
            quo   <= mix_scaled[MIX_SHIFT +: QUO_W];
            state <= S_POST;
          end else begin
            rem   <= num;
            dsh   <= NUM_W'({den, 9'b0});
            ovf   <= (num >= {den, 10'b0});
            quo   <= '0;
            step  <= LAST_STEP;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (fits) begin
            rem <= rem - dsh;
          end
          quo  <= {quo[QUO_W-2:0], fits};
          dsh  <= dsh >> 1;
          step <= step - 1'b1;
          if (step == '0) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          if (phase == PH_MIX) begin
            if (thr == '0) begin
              drv_r <= '0;
              drv_l <= '0;
            end else if (steer[PCT_W-1]) begin
              drv_l <= DRV_W'(sec);
              drv_r <= DRV_W'(thr_ext);
            end else begin
              drv_l <= DRV_W'(thr_ext);
              drv_r <= DRV_W'(sec);
            end
            phase <= PH_RIGHT;
            state <= S_MUL;
          end else begin
            if (phase == PH_RIGHT) begin
              gain_r <= gain_calc;
            end else begin
              gain_l <= gain_calc;
            end
            state <= S_AMUL;
          end
        end
        S_AMUL: begin
          prod  <= mul_p;
          state <= S_ADONE;
        end
        S_ADONE: begin
          if (phase == PH_RIGHT) begin
            adj_r  <= adj;
            prev_r <= mag_sat;
            phase  <= PH_LEFT;
            state  <= S_MUL;
          end else begin
            adj_l  <= adj;
            prev_l <= mag_sat;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || m_tready) begin
            out_data <= {gain_l, gain_r, adj_l, adj_r};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
